>>> hdl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
// Holds opcode codes, message kind codes and the result word layout.
// No dependencies.
`default_nettype none

package wsfd_pkg;

    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_TEXT   = 3'd1;
    localparam logic [2:0] KIND_BINARY = 3'd2;
    localparam logic [2:0] KIND_CLOSE  = 3'd3;
    localparam logic [2:0] KIND_PING   = 3'd4;
    localparam logic [2:0] KIND_PONG   = 3'd5;
    localparam logic [2:0] KIND_ERROR  = 3'd6;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       msg_end;
        logic [2:0] msg_kind;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/wsfd_parser.sv
// Frame header parser and payload unmasker, one byte per accepted word.
// Holds all frame state and forms the result word for each byte.
// Depends on wsfd_pkg.
`default_nettype none

module wsfd_parser
    import wsfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_expect_masked,
    output t_result         o_result
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic        r_fin,         n_fin;
    logic [3:0]  r_opcode,      n_opcode;
    logic [1:0]  r_msg_kind,    n_msg_kind;
    logic [2:0]  r_len_left,    n_len_left;
    logic [63:0] r_payload,     n_payload;
    logic [31:0] r_mask_key,    n_mask_key;
    logic [1:0]  r_mask_idx,    n_mask_idx;
    logic        r_error,       n_error;

    logic        w_is_ctrl;
    logic        w_end_hit;
    logic [2:0]  w_end_kind;
    logic        do_len_done;
    logic        do_hdr_done;
    logic        do_end;
    logic [63:0] w_hdr_len;
    logic [63:0] w_dec;
    t_result     w_res;

    // frame completion report, from the current frame's header
    always_comb begin
        w_is_ctrl = (r_opcode == OPC_CLOSE) || (r_opcode == OPC_PING) ||
                    (r_opcode == OPC_PONG);
        w_end_hit = w_is_ctrl || r_fin;
        if (r_opcode == OPC_CLOSE) begin
            w_end_kind = KIND_CLOSE;
        end else if (r_opcode == OPC_PING) begin
            w_end_kind = KIND_PING;
        end else if (r_opcode == OPC_PONG) begin
            w_end_kind = KIND_PONG;
        end else if (r_msg_kind == 2'd0) begin
            w_end_kind = KIND_TEXT;
        end else begin
            w_end_kind = {1'b0, r_msg_kind};
        end
    end

    assign w_dec = r_payload - 64'd1;

    always_comb begin
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_msg_kind = r_msg_kind;
        n_len_left = r_len_left;
        n_payload  = r_payload;
        n_mask_key = r_mask_key;
        n_mask_idx = r_mask_idx;
        n_error    = r_error;
        do_len_done = 1'b0;
        do_hdr_done = 1'b0;
        do_end      = 1'b0;
        w_hdr_len   = r_payload;
        w_res       = '0;

        if (r_error) begin
            w_res.msg_end  = 1'b1;
            w_res.msg_kind = KIND_ERROR;
        end else begin
            case (r_phase)
                PH_HDR0: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                    case (i_byte[3:0])
                        OPC_TEXT:   n_msg_kind = KIND_TEXT[1:0];
                        OPC_BINARY: n_msg_kind = KIND_BINARY[1:0];
                        OPC_CONT: begin
                            if (r_msg_kind == 2'd0) begin
                                n_msg_kind = KIND_TEXT[1:0];
                            end
                        end
                        OPC_CLOSE, OPC_PING, OPC_PONG: ;
                        default: begin
                            n_error        = 1'b1;
                            n_phase        = r_phase;
                            w_res.msg_end  = 1'b1;
                            w_res.msg_kind = KIND_ERROR;
                        end
                    endcase
                end
                PH_HDR1: begin
                    if (i_byte[7] != i_expect_masked) begin
                        n_error        = 1'b1;
                        w_res.msg_end  = 1'b1;
                        w_res.msg_kind = KIND_ERROR;
                    end else if (i_byte[6:0] == LEN_EXT16) begin
                        n_payload  = '0;
                        n_len_left = 3'd1;
                        n_phase    = PH_EXTLEN;
                    end else if (i_byte[6:0] == LEN_EXT64) begin
                        n_payload  = '0;
                        n_len_left = 3'd7;
                        n_phase    = PH_EXTLEN;
                    end else begin
                        n_len_left  = 3'd0;
                        n_payload   = {57'd0, i_byte[6:0]};
                        w_hdr_len   = {57'd0, i_byte[6:0]};
                        do_len_done = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    n_payload = {r_payload[55:0], i_byte};
                    w_hdr_len = {r_payload[55:0], i_byte};
                    if (r_len_left == 3'd0) begin
                        do_len_done = 1'b1;
                    end else begin
                        n_len_left = r_len_left - 3'd1;
                    end
                end
                PH_KEY: begin
                    n_mask_key = r_mask_key | ({24'd0, i_byte} << {r_mask_idx, 3'b000});
                    if (r_mask_idx == 2'd3) begin
                        do_hdr_done = 1'b1;
                    end else begin
                        n_mask_idx = r_mask_idx + 2'd1;
                    end
                end
                PH_PAYLOAD: begin
                    w_res.data_valid = 1'b1;
                    w_res.data_byte  = i_byte ^ r_mask_key[{r_mask_idx, 3'b000} +: 8];
                    n_mask_idx = r_mask_idx + 2'd1;
                    n_payload  = w_dec;
                    if (w_dec == 64'd0) begin
                        do_end  = 1'b1;
                        n_phase = PH_HDR0;
                    end
                end
                default: n_phase = PH_HDR0;
            endcase

            if (do_len_done) begin
                n_mask_key = '0;
                n_mask_idx = 2'd0;
                if (i_expect_masked) begin
                    n_phase = PH_KEY;
                end else begin
                    do_hdr_done = 1'b1;
                end
            end

            if (do_hdr_done) begin
                n_mask_idx = 2'd0;
                if (w_hdr_len == 64'd0) begin
                    do_end  = 1'b1;
                    n_phase = PH_HDR0;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end

            if (do_end && w_end_hit) begin
                w_res.msg_end  = 1'b1;
                w_res.msg_kind = w_end_kind;
                if (!w_is_ctrl) begin
                    n_msg_kind = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_fin      <= 1'b0;
            r_opcode   <= '0;
            r_msg_kind <= '0;
            r_len_left <= '0;
            r_payload  <= '0;
            r_mask_key <= '0;
            r_mask_idx <= '0;
            r_error    <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_fin      <= n_fin;
            r_opcode   <= n_opcode;
            r_msg_kind <= n_msg_kind;
            r_len_left <= n_len_left;
            r_payload  <= n_payload;
            r_mask_key <= n_mask_key;
            r_mask_idx <= n_mask_idx;
            r_error    <= n_error;
        end
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

>>> hdl/wsfd_out_buf.sv
// Output register with skid stage for result words.
// Lets the input side accept one more word while a result waits downstream.
// Depends on wsfd_pkg.
`default_nettype none

module wsfd_out_buf
    import wsfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_in_ready,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_out_free;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_in_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/websocket_frame_decoder.sv
// Top level of the WebSocket frame decoder: config register, parser, output buffer.
// Depends on wsfd_pkg, wsfd_parser and wsfd_out_buf.
`default_nettype none

// Takes one stream byte per cycle and returns one result word per byte, in the
// cycle after acceptance at the earliest. Throughput is one byte every clock
// as long as the master side keeps tready high; the whole header, countdown
// and unmask update for a byte, including the 64-bit length countdown, is
// combinational and registered on acceptance. A two-entry output buffer lets
// the slave side keep accepting for one word while a result waits.
// expect_masked applies to the next byte after it is written.

module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] data_byte
    output logic            m_axis_tlast,   // msg_end
    output logic [3:0]      m_axis_tuser    // [0] data_valid, [3:1] msg_kind
);

    logic    r_expect_masked;
    logic    w_accept;
    t_result w_result;
    t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_masked <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_expect_masked <= i_cfg_wr_data;
        end
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    wsfd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_byte          (s_axis_tdata),
        .i_expect_masked (r_expect_masked),
        .o_result        (w_result)
    );

    wsfd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_data     (w_result),
        .o_in_ready (s_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (w_out),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = w_out.data_byte;
    assign m_axis_tlast = w_out.msg_end;
    assign m_axis_tuser = {w_out.msg_kind, w_out.data_valid};

endmodule

`default_nettype wire

>>> hdl/wsfd_checker.sv
// Port-level checks for the WebSocket frame decoder, bound to the top level.
// Depends on wsfd_pkg and websocket_frame_decoder.
`default_nettype none

module wsfd_checker
    import wsfd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic [3:0] m_axis_tuser
);

    logic r_err_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[3:1] == KIND_ERROR) begin
            r_err_seen <= 1'b1;
        end
    end

    a_kind_iff_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[3:1] != KIND_NONE)))
        else $error("msg_kind and msg_end disagree");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (!m_axis_tuser[0] || m_axis_tuser[3:1] == KIND_ERROR))
        |-> (m_axis_tdata == 8'd0 && !m_axis_tuser[0]))
        else $error("data byte set without payload word");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_err_seen) |-> (m_axis_tuser[3:1] == KIND_ERROR))
        else $error("word after error is not an error report");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
        else $error("stalled result word changed");

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for websocket_frame_decoder: drives framed byte streams,
// predicts each result word with a cycle-free decoder model and checks every field.
// Depends on wsfd_pkg and the decoder RTL.

module tb
    import wsfd_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 300;

    typedef enum logic [2:0] {PH_HDR0, PH_HDR1, PH_EXTLEN, PH_KEY, PH_PAYLOAD} t_rx_phase;
    typedef enum int {FMT_SHORT, FMT_16, FMT_64} t_len_fmt;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [3:0] m_axis_tuser;

    // decoder model state
    logic        mode_masked = 1'b0;
    t_rx_phase   rx_phase = PH_HDR0;
    logic        hdr_fin = 1'b0;
    logic [3:0]  hdr_opcode = OPC_CONT;
    logic [2:0]  open_kind = KIND_NONE;
    logic [2:0]  ext_left = '0;
    logic [63:0] pay_left = '0;
    logic [31:0] key_word = '0;
    logic [1:0]  key_idx = '0;
    logic        err_latched = 1'b0;

    t_result expected_words[$];
    int n_sent = 0;
    int n_checked = 0;
    int n_fail = 0;
    int src_idle_pct = 33;
    int rx_idle_pct = 33;
    int rx_hold = 0;
    logic rx_hold_req = 1'b0;
    int stall_cycles = 0;

    websocket_frame_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result error_word();
        t_result r;
        r = '0;
        r.msg_end = 1'b1;
        r.msg_kind = KIND_ERROR;
        return r;
    endfunction

    function automatic void close_frame(inout t_result r);
        if (hdr_opcode == OPC_CLOSE) begin
            r.msg_end = 1'b1;
            r.msg_kind = KIND_CLOSE;
        end else if (hdr_opcode == OPC_PING) begin
            r.msg_end = 1'b1;
            r.msg_kind = KIND_PING;
        end else if (hdr_opcode == OPC_PONG) begin
            r.msg_end = 1'b1;
            r.msg_kind = KIND_PONG;
        end else if (hdr_fin) begin
            r.msg_end = 1'b1;
            r.msg_kind = (open_kind == KIND_NONE) ? KIND_TEXT : open_kind;
            open_kind = KIND_NONE;
        end
    endfunction

    function automatic void finish_header(inout t_result r);
        key_idx = '0;
        if (pay_left == 0) begin
            close_frame(r);
            rx_phase = PH_HDR0;
        end else begin
            rx_phase = PH_PAYLOAD;
        end
    endfunction

    function automatic void finish_length(inout t_result r);
        key_word = '0;
        key_idx = '0;
        if (mode_masked)
            rx_phase = PH_KEY;
        else
            finish_header(r);
    endfunction

    function automatic t_result ws_decode_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        if (err_latched)
            return error_word();
        case (rx_phase)
            PH_HDR0: begin
                hdr_fin = b[7];
                hdr_opcode = b[3:0];
                case (hdr_opcode)
                    OPC_TEXT:   open_kind = KIND_TEXT;
                    OPC_BINARY: open_kind = KIND_BINARY;
                    OPC_CONT: begin
                        if (open_kind == KIND_NONE)
                            open_kind = KIND_TEXT;
                    end
                    OPC_CLOSE, OPC_PING, OPC_PONG: ;
                    default: begin
                        err_latched = 1'b1;
                        return error_word();
                    end
                endcase
                rx_phase = PH_HDR1;
            end
            PH_HDR1: begin
                if (b[7] != mode_masked) begin
                    err_latched = 1'b1;
                    return error_word();
                end
                pay_left = '0;
                if (b[6:0] == LEN_EXT16) begin
                    ext_left = 3'd1;
                    rx_phase = PH_EXTLEN;
                end else if (b[6:0] == LEN_EXT64) begin
                    ext_left = 3'd7;
                    rx_phase = PH_EXTLEN;
                end else begin
                    ext_left = '0;
                    pay_left = 64'(b[6:0]);
                    finish_length(r);
                end
            end
            PH_EXTLEN: begin
                pay_left = {pay_left[55:0], b};
                if (ext_left == 0)
                    finish_length(r);
                else
                    ext_left = ext_left - 3'd1;
            end
            PH_KEY: begin
                key_word[8*key_idx +: 8] = b;
                if (key_idx == 2'd3)
                    finish_header(r);
                else
                    key_idx = key_idx + 2'd1;
            end
            PH_PAYLOAD: begin
                r.data_valid = 1'b1;
                r.data_byte = b ^ key_word[8*key_idx +: 8];
                key_idx = key_idx + 2'd1;
                pay_left = pay_left - 64'd1;
                if (pay_left == 0) begin
                    close_frame(r);
                    rx_phase = PH_HDR0;
                end
            end
            default: rx_phase = PH_HDR0;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data_valid = m_axis_tuser[0];
            got.data_byte = m_axis_tdata;
            got.msg_end = m_axis_tlast;
            got.msg_kind = m_axis_tuser[3:1];
            if (expected_words.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("word %0d: unexpected, got v=%b d=%02h end=%b kind=%0d",
                             n_checked, got.data_valid, got.data_byte, got.msg_end,
                             got.msg_kind);
            end else begin
                want = expected_words.pop_front();
                if (got.data_valid !== want.data_valid ||
                    got.data_byte !== want.data_byte ||
                    got.msg_end !== want.msg_end || got.msg_kind !== want.msg_kind) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("word %0d: want v=%b d=%02h end=%b kind=%0d,",
                                 n_checked, want.data_valid, want.data_byte, want.msg_end,
                                 want.msg_kind, " got v=%b d=%02h end=%b kind=%0d",
                                 got.data_valid, got.data_byte, got.msg_end,
                                 got.msg_kind);
                end
            end
            n_checked++;
        end
    end

    // receiver ready, with an on-request long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_hold_req) begin
            m_axis_tready <= 1'b0;
            rx_hold <= RX_HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        expected_words.insert(expected_words.size(), ws_decode_byte(b));
        n_sent++;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic masked);
        wait_all_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= masked;
        @(posedge i_clk);
        mode_masked = masked;
        i_cfg_wr_en <= 1'b0;
    endtask

    // well-formed frame; n_pay payload bytes follow the header
    task automatic send_frame(input logic [3:0] opc, input logic fin, input logic [63:0] len,
                              input t_len_fmt fmt, input int n_pay);
        logic [2:0] rsv;
        rsv = 3'($urandom);
        send_byte({fin, rsv, opc});
        case (fmt)
            FMT_16: begin
                send_byte({mode_masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            FMT_64: begin
                send_byte({mode_masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            default: send_byte({mode_masked, len[6:0]});
        endcase
        if (mode_masked)
            repeat (4) send_byte(8'($urandom));
        repeat (n_pay) send_byte(8'($urandom));
    endtask

    task automatic send_random_frame();
        int pick;
        logic [3:0] opc;
        logic [63:0] len;
        t_len_fmt fmt;
        pick = $urandom_range(99);
        if (pick < 25)
            opc = OPC_CONT;
        else if (pick < 50)
            opc = OPC_TEXT;
        else if (pick < 70)
            opc = OPC_BINARY;
        else if (pick < 80)
            opc = OPC_CLOSE;
        else if (pick < 90)
            opc = OPC_PING;
        else
            opc = OPC_PONG;
        pick = $urandom_range(99);
        if (pick < 80) begin
            fmt = FMT_SHORT;
            len = 64'(($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(12));
        end else if (pick < 95) begin
            fmt = FMT_16;
            len = 64'($urandom_range(300));
        end else begin
            fmt = FMT_64;
            len = 64'($urandom_range(40));
        end
        send_frame(opc, 1'($urandom), len, fmt, int'(len));
    endtask

    task automatic run_random_frames(input int n);
        int stop_at;
        stop_at = n_sent + n;
        while (n_sent < stop_at)
            send_random_frame();
    endtask

    task automatic test_unmasked_frames();
        write_mode(1'b0);
        send_frame(OPC_TEXT, 1'b1, 64'd3, FMT_SHORT, 3);
        send_frame(OPC_BINARY, 1'b1, 64'd0, FMT_SHORT, 0);
        // fragmented text with a ping (FIN clear) in the middle
        send_frame(OPC_TEXT, 1'b0, 64'd1, FMT_SHORT, 1);
        send_frame(OPC_PING, 1'b0, 64'd1, FMT_SHORT, 1);
        send_frame(OPC_CONT, 1'b1, 64'd2, FMT_SHORT, 2);
        // continuation with nothing open
        send_frame(OPC_CONT, 1'b1, 64'd0, FMT_SHORT, 0);
        // open binary dropped by a new text message
        send_frame(OPC_BINARY, 1'b0, 64'd1, FMT_SHORT, 1);
        send_frame(OPC_TEXT, 1'b1, 64'd1, FMT_SHORT, 1);
    endtask

    task automatic test_masked_frames();
        write_mode(1'b1);
        send_frame(OPC_CLOSE, 1'b1, 64'd5, FMT_SHORT, 5);
        send_frame(OPC_PONG, 1'b1, 64'd0, FMT_SHORT, 0);
        send_frame(OPC_BINARY, 1'b1, 64'd4, FMT_16, 4);
        send_frame(OPC_TEXT, 1'b1, 64'd2, FMT_64, 2);
    endtask

    // mask bit checked under the old mode, key decided under the new one
    task automatic test_mode_change_in_length();
        write_mode(1'b0);
        send_byte({1'b1, 3'b000, OPC_BINARY});
        send_byte({1'b0, LEN_EXT16});
        send_byte(8'h00);
        write_mode(1'b1);
        send_byte(8'h03);
        repeat (4) send_byte(8'($urandom));
        repeat (3) send_byte(8'($urandom));
    endtask

    task automatic test_random_masked();
        write_mode(1'b1);
        run_random_frames(400);
    endtask

    task automatic test_random_no_idle();
        write_mode(1'b0);
        src_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_frames(300);
        src_idle_pct = 33;
        rx_idle_pct = 33;
    endtask

    task automatic test_output_stall();
        write_mode(1'b1);
        rx_hold_req = 1'b1;
        wait (rx_hold != 0);
        rx_hold_req = 1'b0;
        run_random_frames(250);
    endtask

    task automatic test_random_unmasked();
        write_mode(1'b0);
        run_random_frames(400);
    endtask

    // only one terminal case fits per run: bad opcode, bad mask bit, or a huge length
    task automatic test_terminal_case();
        int pick;
        logic [3:0] opc;
        wait_all_results();
        pick = $urandom_range(9);
        case ($urandom_range(2))
            0: begin
                opc = (pick < 5) ? OPC_BINARY + 4'(1 + pick) : OPC_PONG + 4'(pick - 4);
                send_byte({1'($urandom), 3'($urandom), opc});
            end
            1: begin
                send_byte({1'b1, 3'b000, OPC_TEXT});
                send_byte({~mode_masked, 7'($urandom)});
            end
            default: begin
                send_frame(OPC_BINARY, 1'b1, {1'b1, 31'($urandom), 32'($urandom)}, FMT_64, 30);
            end
        endcase
        repeat (20) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unmasked_frames();
        test_masked_frames();
        test_mode_change_in_length();
        test_random_masked();
        test_random_no_idle();
        test_output_stall();
        test_random_unmasked();
        test_terminal_case();
        wait_all_results();
        repeat (16) @(posedge i_clk);
        if (expected_words.size() != 0)
            $display("%0d expected words never arrived", expected_words.size());
        if (n_fail == 0 && expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
